>>> src/vsac_pkg.sv
// Shared types, constants and helpers of the volatility surface arbitrage checker.
`default_nettype none
package vsac_pkg;

  localparam int unsigned MAX_STRIKES_DEF    = 64;
  localparam int unsigned MAX_MATURITIES_DEF = 64;

  // strike index carried through the queue; wide enough for the largest grid
  localparam int unsigned IDX_W       = 10;
  localparam int unsigned OUT_IDX_W   = 6;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPOT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_MAG = 1'b1;

  localparam logic [31:0] SPOT_RESET = 32'd6553600;
  localparam logic [31:0] LN2_Q32    = 32'd2977044472;
  localparam logic [31:0] SAT32      = 32'hFFFF_FFFF;

  localparam logic KIND_CAL  = 1'b0;
  localparam logic KIND_BFLY = 1'b1;

  localparam int unsigned DIV_NUM_W = 56;
  localparam int unsigned DIV_CNT_W = 6;
  localparam logic [DIV_CNT_W-1:0] SLOPE_BITS = 6'd56;
  localparam logic [DIV_CNT_W-1:0] MAG_BITS   = 6'd32;

  typedef struct packed {
    logic [31:0]          strike;
    logic [23:0]          maturity;
    logic [15:0]          call_iv;
    logic [15:0]          put_iv;
    logic [IDX_W-1:0]     s_idx;
    logic [OUT_IDX_W-1:0] row_lo;
    logic                 have_prev;
  } item_t;

  typedef struct packed {
    logic                 start;
    logic [31:0]          rem0;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_CNT_W-1:0] nbits;
    logic [31:0]          den;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic [DIV_NUM_W-1:0] quot;
  } div_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE, S_SQ_C, S_VAR_C, S_SQ_P, S_VAR_P, S_CAL, S_NORM, S_SQR, S_LN,
    S_BF_CHK, S_D1_GO, S_D1_WT, S_D2_GO, S_D2_WT, S_MAG, S_MAG_WT, S_FIN, S_EMIT
  } back_state_t;

  // Q20.44 product down to Q8.24, saturating
  function automatic logic [31:0] sat_var(input logic [63:0] p);
    logic [31:0] r;
    if (p[63:52] != 12'd0) r = SAT32;
    else r = p[51:20];
    return r;
  endfunction

endpackage
`default_nettype wire

>>> src/vsac_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module vsac_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> src/vsac_fifo.sv
// Short request queue between the classifying front and the compute back.
`default_nettype none
module vsac_fifo import vsac_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire item_t push_data,
  output      logic  full,
  input  wire logic  pop,
  output      logic  empty,
  output      item_t pop_data
);

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);

  item_t           ent_r [QUEUE_DEPTH];
  logic [PW-1:0]   wp_r, rp_r;
  logic [PW:0]     cnt_r;

  assign full     = (cnt_r == (PW+1)'(QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      ent_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push && !full) wp_r <= wp_r + 1'b1;
      if (pop && !empty) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(push && !full) - (PW+1)'(pop && !empty);
    end
  end

`ifndef SYNTH
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !empty) else $error("queue full and empty at once");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (PW+1)'(QUEUE_DEPTH)) else $error("queue count overrun");
  a_pop_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !empty && !push) |=> cnt_r == $past(cnt_r) - 1'b1)
    else $error("pop did not drain an entry");
`endif

endmodule
`default_nettype wire

>>> src/vsac_front.sv
// Front end: accepts grid points, tracks row and strike position, drops overflow points.
`default_nettype none
module vsac_front import vsac_pkg::*; #(
  parameter int unsigned MAX_STRIKES    = MAX_STRIKES_DEF,
  parameter int unsigned MAX_MATURITIES = MAX_MATURITIES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        accept,
  input  wire logic [31:0] strike,
  input  wire logic [23:0] maturity,
  input  wire logic [15:0] call_iv,
  input  wire logic [15:0] put_iv,
  input  wire logic        row_start,
  input  wire logic        surface_start,
  output      logic        push,
  output      item_t       push_data
);

  localparam int unsigned SCW = $clog2(MAX_STRIKES + 1);
  localparam int unsigned RCW = $clog2(MAX_MATURITIES + 1);

  logic [SCW-1:0] sc_r, sc_nxt, sc_a;
  logic [RCW-1:0] rc_r, rc_nxt, rc_a;
  logic           hp_r, hp_nxt, hp_a;
  logic           ignore;

  always_comb begin
    sc_a = sc_r;
    rc_a = rc_r;
    hp_a = hp_r;
    if (surface_start) begin
      sc_a = '0;
      rc_a = '0;
      hp_a = 1'b0;
    end else if (row_start && sc_r != '0) begin
      hp_a = 1'b1;
      if (rc_r < RCW'(MAX_MATURITIES)) rc_a = rc_r + 1'b1;
      sc_a = '0;
    end
    ignore = (sc_a >= SCW'(MAX_STRIKES)) || (rc_a >= RCW'(MAX_MATURITIES));

    push                = accept && !ignore;
    push_data.strike    = strike;
    push_data.maturity  = maturity;
    push_data.call_iv   = call_iv;
    push_data.put_iv    = put_iv;
    push_data.s_idx     = IDX_W'(sc_a);
    push_data.row_lo    = OUT_IDX_W'(rc_a);
    push_data.have_prev = hp_a;

    sc_nxt = sc_r;
    rc_nxt = rc_r;
    hp_nxt = hp_r;
    if (accept) begin
      sc_nxt = ignore ? sc_a : sc_a + 1'b1;
      rc_nxt = rc_a;
      hp_nxt = hp_a;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_r <= '0;
      rc_r <= '0;
      hp_r <= 1'b0;
    end else begin
      sc_r <= sc_nxt;
      rc_r <= rc_nxt;
      hp_r <= hp_nxt;
    end
  end

endmodule
`default_nettype wire

>>> src/vsac_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module vsac_div import vsac_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output      div_rsp_t rsp
);

  logic [31:0]          rem_r, den_r;
  logic [DIV_NUM_W-1:0] num_r, q_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic [32:0]          trial;
  logic                 take;

  assign trial    = {rem_r, num_r[DIV_NUM_W-1]};
  assign take     = trial >= {1'b0, den_r};
  assign rsp.busy = busy_r;
  assign rsp.quot = q_r;

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.rem0;
      num_r <= req.num;
      den_r <= req.den;
      q_r   <= '0;
      cnt_r <= req.nbits;
    end else if (busy_r) begin
      rem_r <= take ? 32'(trial - {1'b0, den_r}) : trial[31:0];
      q_r   <= {q_r[DIV_NUM_W-2:0], take};
      num_r <= num_r << 1;
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (req.start) begin
      busy_r <= 1'b1;
    end else if (busy_r && cnt_r == DIV_CNT_W'(1)) begin
      busy_r <= 1'b0;
    end
  end

endmodule
`default_nettype wire

>>> src/vsac_back.sv
// Back end: variance, log-moneyness, calendar and butterfly checks, result emission.
`default_nettype none
module vsac_back import vsac_pkg::*; #(
  parameter int unsigned MAX_STRIKES = MAX_STRIKES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_empty,
  input  wire item_t       q_data,
  output      logic        q_pop,
  input  wire logic [31:0] spot,
  input  wire logic [31:0] min_mag,
  output      div_req_t    div_req,
  input  wire div_rsp_t    div_rsp,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic        out_kind,
  output      logic        out_side,
  output      logic [5:0]  out_row,
  output      logic [5:0]  out_strike,
  output      logic [31:0] out_mag,
  output      logic        out_last
);

  localparam int unsigned AW = $clog2(MAX_STRIKES);

  back_state_t state_r, state_nxt;

  item_t              cur_r;
  logic [31:0]        sq_r, wc_r, wp_r, m_r;
  logic [4:0]         p_r, it_r;
  logic [23:0]        f_r;
  logic               lsel_r, side_r, neg_r;
  logic [28:0]        lgk_r;
  logic signed [31:0] lm_r, rl0_r, rl1_r;
  logic [31:0]        rc0_r, rc1_r, rp0_r, rp1_r, h1_r, h2_r;
  logic signed [57:0] s1_r, s2_r;
  logic [3:0]         hit_r;
  logic [31:0]        mag_r [4];
  logic               out_valid_r;

  logic [31:0]        mul_a, mul_b;
  logic [63:0]        prod;
  logic [63:0]        oc_op;
  logic [31:0]        oc, op;
  logic [32:0]        sqv;
  logic [23:0]        f_nxt;
  logic signed [29:0] dlog;
  logic [28:0]        dabs;
  logic [63:0]        rnd;
  logic signed [32:0] h1, h2, dd;
  logic [31:0]        dabs32, w0, w1, w2, span;
  logic signed [57:0] mm;
  logic               bf_ok, mag_sat, out_load;
  logic [1:0]         k;
  logic [55:0]        qv;

  vsac_ram #(.WIDTH(64), .DEPTH(MAX_STRIKES)) u_prev_row (
    .clk   (clk),
    .we    (state_r == S_CAL),
    .waddr (cur_r.s_idx[AW-1:0]),
    .wdata ({wc_r, wp_r}),
    .re    (q_pop),
    .raddr (q_data.s_idx[AW-1:0]),
    .rdata (oc_op)
  );

  assign oc = oc_op[63:32];
  assign op = oc_op[31:0];

  // single shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_SQ_C:  begin mul_a = 32'(cur_r.call_iv); mul_b = 32'(cur_r.call_iv); end
      S_SQ_P:  begin mul_a = 32'(cur_r.put_iv);  mul_b = 32'(cur_r.put_iv);  end
      S_VAR_C,
      S_VAR_P: begin mul_a = sq_r; mul_b = 32'(cur_r.maturity); end
      S_SQR:   begin mul_a = m_r;  mul_b = m_r; end
      S_LN:    begin mul_a = 32'(dabs); mul_b = LN2_Q32; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end
  assign prod = mul_a * mul_b;

  always_comb begin
    sqv    = prod[63:31];
    f_nxt  = {f_r[22:0], sqv[32]};
    dlog   = $signed({1'b0, lgk_r}) - $signed({1'b0, p_r, f_r});
    dabs   = dlog[29] ? 29'(-dlog) : dlog[28:0];
    rnd    = prod + 64'h8000_0000;
    h1     = {rl1_r[31], rl1_r} - {rl0_r[31], rl0_r};
    h2     = {lm_r[31], lm_r} - {rl1_r[31], rl1_r};
    bf_ok  = (cur_r.s_idx >= IDX_W'(2)) && !h1[32] && (h1 != '0) && !h2[32] && (h2 != '0);
    w0     = side_r ? rp0_r : rc0_r;
    w1     = side_r ? rp1_r : rc1_r;
    w2     = side_r ? wp_r  : wc_r;
    if (state_r == S_D2_GO) dd = $signed({1'b0, w2}) - $signed({1'b0, w1});
    else dd = $signed({1'b0, w1}) - $signed({1'b0, w0});
    dabs32 = dd[32] ? 32'(-dd) : dd[31:0];
    span   = h1_r + h2_r;
    mm     = s1_r - s2_r;
    mag_sat = mm >= $signed({19'd0, span, 7'd0});
    qv     = div_rsp.quot;
    k      = 2'd0;
    for (int i = 3; i >= 0; i--) begin
      if (hit_r[i]) k = 2'(i);
    end
    out_load = (!out_valid_r || out_ready) && (hit_r != '0) && (state_r == S_EMIT);
  end

  // next state and handshakes
  always_comb begin
    state_nxt     = state_r;
    q_pop         = 1'b0;
    div_req.start = 1'b0;
    div_req.rem0  = '0;
    div_req.num   = {dabs32, 24'd0};
    div_req.nbits = SLOPE_BITS;
    div_req.den   = (state_r == S_D2_GO) ? h2_r : h1_r;
    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          state_nxt = S_SQ_C;
        end
      end
      S_SQ_C:  state_nxt = S_VAR_C;
      S_VAR_C: state_nxt = S_SQ_P;
      S_SQ_P:  state_nxt = S_VAR_P;
      S_VAR_P: state_nxt = S_CAL;
      S_CAL:   state_nxt = S_NORM;
      S_NORM:  if (m_r[31]) state_nxt = S_SQR;
      S_SQR:   if (it_r == 5'd23) state_nxt = lsel_r ? S_LN : S_NORM;
      S_LN:    state_nxt = S_BF_CHK;
      S_BF_CHK: state_nxt = bf_ok ? S_D1_GO : S_FIN;
      S_D1_GO: begin
        div_req.start = 1'b1;
        state_nxt     = S_D1_WT;
      end
      S_D1_WT: if (!div_rsp.busy) state_nxt = S_D2_GO;
      S_D2_GO: begin
        div_req.start = 1'b1;
        state_nxt     = S_D2_WT;
      end
      S_D2_WT: if (!div_rsp.busy) state_nxt = S_MAG;
      S_MAG: begin
        if (s2_r >= s1_r || mag_sat) begin
          state_nxt = side_r ? S_FIN : S_D1_GO;
        end else begin
          div_req.start = 1'b1;
          div_req.rem0  = mm[38:7];
          div_req.num   = {mm[6:0], 49'd0};
          div_req.nbits = MAG_BITS;
          div_req.den   = span;
          state_nxt     = S_MAG_WT;
        end
      end
      S_MAG_WT: if (!div_rsp.busy) state_nxt = side_r ? S_FIN : S_D1_GO;
      S_FIN:  state_nxt = S_EMIT;
      S_EMIT: if (hit_r == '0) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r       <= '0;
      out_valid_r <= 1'b0;
      rl0_r <= '0; rl1_r <= '0;
      rc0_r <= '0; rc1_r <= '0;
      rp0_r <= '0; rp1_r <= '0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
        hit_r[k]    <= 1'b0;
        out_kind    <= k[1];
        out_side    <= k[0];
        out_row     <= (k[1] == KIND_BFLY) ? cur_r.row_lo : cur_r.row_lo - 1'b1;
        out_strike  <= (k[1] == KIND_BFLY) ? 6'(cur_r.s_idx) - 6'd2 : 6'(cur_r.s_idx);
        out_mag     <= mag_r[k];
        out_last    <= (hit_r & ~(4'b0001 << k)) == 4'd0;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: if (!q_empty) cur_r <= q_data;
        S_SQ_C, S_SQ_P: sq_r <= prod[31:0];
        S_VAR_C: wc_r <= sat_var(prod);
        S_VAR_P: wp_r <= sat_var(prod);
        S_CAL: begin
          // calendar: variance below the stored one at this strike
          hit_r[0]   <= cur_r.have_prev && (wc_r < oc) && ((oc - wc_r) >= min_mag);
          hit_r[1]   <= cur_r.have_prev && (wp_r < op) && ((op - wp_r) >= min_mag);
          mag_r[0]   <= oc - wc_r;
          mag_r[1]   <= op - wp_r;
          lsel_r     <= 1'b0;
          m_r        <= (cur_r.strike == '0) ? 32'd1 : cur_r.strike;
          p_r        <= 5'd31;
        end
        S_NORM: begin
          if (m_r[31]) begin
            it_r <= '0;
            f_r  <= '0;
          end else begin
            m_r <= m_r << 1;
            p_r <= p_r - 1'b1;
          end
        end
        S_SQR: begin
          f_r  <= f_nxt;
          it_r <= it_r + 1'b1;
          if (it_r == 5'd23 && !lsel_r) begin
            lgk_r  <= {p_r, f_nxt};
            lsel_r <= 1'b1;
            m_r    <= (spot == '0) ? 32'd1 : spot;
            p_r    <= 5'd31;
          end else begin
            m_r <= sqv[32] ? sqv[32:1] : sqv[31:0];
          end
        end
        S_LN: lm_r <= dlog[29] ? -$signed(32'(rnd[60:32])) : $signed(32'(rnd[60:32]));
        S_BF_CHK: begin
          h1_r   <= h1[31:0];
          h2_r   <= h2[31:0];
          side_r <= 1'b0;
        end
        S_D1_GO, S_D2_GO: neg_r <= dd[32];
        S_D1_WT: s1_r <= neg_r ? -$signed({2'b00, qv}) : $signed({2'b00, qv});
        S_D2_WT: s2_r <= neg_r ? -$signed({2'b00, qv}) : $signed({2'b00, qv});
        S_MAG: begin
          if (s2_r < s1_r && mag_sat) begin
            hit_r[{1'b1, side_r}] <= SAT32 >= min_mag;
            mag_r[{1'b1, side_r}] <= SAT32;
          end
          if (s2_r >= s1_r || mag_sat) side_r <= 1'b1;
        end
        S_MAG_WT: begin
          if (!div_rsp.busy) begin
            hit_r[{1'b1, side_r}] <= qv[31:0] >= min_mag;
            mag_r[{1'b1, side_r}] <= qv[31:0];
            side_r                <= 1'b1;
          end
        end
        S_FIN: begin
          rl0_r <= rl1_r; rl1_r <= lm_r;
          rc0_r <= rc1_r; rc1_r <= wc_r;
          rp0_r <= rp1_r; rp1_r <= wp_r;
        end
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTH
  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy) else $error("divider restarted while busy");
  a_idle_no_hits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> hit_r == '0) else $error("pending hits left behind");
  a_rise_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EMIT)) else $error("result outside emit");
`endif

endmodule
`default_nettype wire

>>> src/vol_surface_arbitrage_checker.sv
// Top level: ports, configuration registers, front, queue, divider and back.
// Sequencing: one point at a time; pop, variance and calendar, then log2 of strike and
// spot, bookkeeping, up to two slope divides and one magnitude divide per side in the
// serial divider, then the results are emitted one by one.
// Reset: rst_n synchronous, active low; clears counters, queue, sequencer and
// config (spot 100.0, threshold 0); the strike history RAM is left as is.
`default_nettype none
module vol_surface_arbitrage_checker import vsac_pkg::*; #(
  parameter int unsigned MAX_STRIKES    = MAX_STRIKES_DEF,
  parameter int unsigned MAX_MATURITIES = MAX_MATURITIES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // strike[31:0], maturity[55:32], call_iv[71:56], put_iv[87:72]
  input  wire logic [87:0]          in_tdata,
  // row_start[0], surface_start[1]
  input  wire logic [1:0]           in_tuser,
  input  wire logic                 in_tvalid,
  output      logic                 in_tready,
  // row_index[5:0], strike_index[11:6], magnitude[43:12], zero fill[47:44]
  output      logic [47:0]          out_tdata,
  // kind[0], side[1]
  output      logic [1:0]           out_tuser,
  output      logic                 out_tlast,
  output      logic                 out_tvalid,
  input  wire logic                 out_tready,
  input  wire logic                 cfg_valid,
  output      logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data
);

  logic [31:0] spot_r, min_mag_r;
  logic        q_push, q_full, q_pop, q_empty;
  item_t       q_in, q_out;
  div_req_t    div_req;
  div_rsp_t    div_rsp;
  logic        o_kind, o_side;
  logic [5:0]  o_row, o_strike;
  logic [31:0] o_mag;

  // config must be written only while idle; the block itself does not enforce it; always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spot_r    <= SPOT_RESET;
      min_mag_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SPOT:    spot_r    <= cfg_data;
        CFG_MIN_MAG: min_mag_r <= cfg_data;
        default:     ;
      endcase
    end
  end

  // hold requests off only when the queue is full
  assign in_tready = !q_full;

  vsac_front #(.MAX_STRIKES(MAX_STRIKES), .MAX_MATURITIES(MAX_MATURITIES)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (in_tvalid && in_tready),
    .strike        (in_tdata[31:0]),
    .maturity      (in_tdata[55:32]),
    .call_iv       (in_tdata[71:56]),
    .put_iv        (in_tdata[87:72]),
    .row_start     (in_tuser[0]),
    .surface_start (in_tuser[1]),
    .push          (q_push),
    .push_data     (q_in)
  );

  vsac_fifo u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_data  (q_out)
  );

  vsac_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  vsac_back #(.MAX_STRIKES(MAX_STRIKES)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_data     (q_out),
    .q_pop      (q_pop),
    .spot       (spot_r),
    .min_mag    (min_mag_r),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_kind   (o_kind),
    .out_side   (o_side),
    .out_row    (o_row),
    .out_strike (o_strike),
    .out_mag    (o_mag),
    .out_last   (out_tlast)
  );

  assign out_tdata = {4'd0, o_mag, o_strike, o_row};
  assign out_tuser = {o_side, o_kind};

endmodule
`default_nettype wire
